// File: sv/bctt_pkg.sv
// Shared types and codes for the block cache tag table.
// Field widths, operation and status codes, and the packed entry record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bctt_pkg;

    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;
    localparam int IDX_IN_W = 5;
    localparam int CNT_W   = 8;
    localparam int STAMP_W = 32;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;

    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PIN     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNPIN   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_COUNT = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [DEV_W-1:0]   dev;
        logic [BLK_W-1:0]   blk;
        logic               valid;
        logic [CNT_W-1:0]   cnt;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

`default_nettype wire

// File: sv/block_cache_tag_table_lru.sv
// Channel   Dir  Word                                            Accepted when
// s_        in   tuser: mode; tdata: device, block, index, now   s_tvalid & s_tready
// m_        out  tdata: entry, hit, needs_fill, status           m_tvalid & m_tready
//
// Lookup does one read of the entry memory per cycle over every entry, waits for the last
// read to land, closes the scan, then writes back.
// Release, pin and unpin read the entry, capture it, then write it back. One word at a time.
// Reset clears the per-entry live bits; an entry never written reads as all zero.
// A stalled result holds the write back until the output register frees up.
// Depends on bctt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module block_cache_tag_table_lru
    import bctt_pkg::*;
#(
    parameter int NUM_ENTRIES = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [1:0] mode
    input  wire logic [1:0]   s_tuser,
    // [7:0] device, [39:8] block_number, [44:40] entry_index, [76:45] now, [79:77] zero
    input  wire logic [79:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [4:0] entry_out, [5] hit, [6] needs_fill, [8:7] status, [15:9] zero
    output logic [15:0]       m_tdata
);

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int SCAN_W = $clog2(NUM_ENTRIES + 1);
    localparam int WIDE_W = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_ADJ_RD = 3'd2;
    localparam logic [2:0] S_ADJ    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    entry_t mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] live_reg;

    logic [2:0]           state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [DEV_W-1:0]     dev_reg, dev_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [IDX_IN_W-1:0]  idx_reg, idx_next;
    logic [STAMP_W-1:0]   now_reg, now_next;
    logic [SCAN_W-1:0]    scan_reg, scan_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    entry_t               hit_rec_reg, hit_rec_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [STAMP_W-1:0]   oldest_reg, oldest_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [15:0]          m_tdata_reg, m_tdata_next;

    entry_t               rd_data_reg;
    logic                 rd_live_reg;
    entry_t               rd_entry;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    logic                 out_free;
    logic [IDX_W-1:0]     idx_addr;
    logic                 idx_ok;
    logic [WIDE_W-1:0]    hit_wide;
    logic [WIDE_W-1:0]    free_wide;
    logic [IDX_IN_W-1:0]  e_out;
    logic                 r_hit;
    logic                 r_fill;
    logic [STAT_W-1:0]    r_stat;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_entry = rd_live_reg ? rd_data_reg : '0;
    assign idx_addr = IDX_W'(WIDE_W'(idx_reg));
    assign idx_ok   = (32'(idx_reg) < NUM_ENTRIES);
    assign hit_wide  = WIDE_W'(hit_idx_reg);
    assign free_wide = WIDE_W'(free_idx_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_live_reg <= live_reg[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        dev_next        = dev_reg;
        blk_next        = blk_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rec_next    = hit_rec_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        oldest_next     = oldest_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = hit_rec_reg;
        e_out           = idx_reg;
        r_hit           = 1'b0;
        r_fill          = 1'b0;
        r_stat          = ST_OK;

        // fold in the entry read on the previous cycle
        if (cmp_vld_reg) begin
            if (!hit_found_reg && rd_entry.dev == dev_reg && rd_entry.blk == blk_reg) begin
                hit_found_next = 1'b1;
                hit_idx_next   = cmp_idx_reg;
                hit_rec_next   = rd_entry;
            end
            if (rd_entry.cnt == '0 && (!free_found_reg || rd_entry.stamp < oldest_reg)) begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
                oldest_next     = rd_entry.stamp;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next       = s_tuser;
                    dev_next        = s_tdata[7:0];
                    blk_next        = s_tdata[39:8];
                    idx_next        = s_tdata[44:40];
                    now_next        = s_tdata[76:45];
                    scan_next       = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = (s_tuser == MODE_LOOKUP) ? S_SCAN : S_ADJ_RD;
                end
            end
            S_SCAN: begin
                if (32'(scan_reg) < NUM_ENTRIES) begin
                    rd_addr      = scan_reg[IDX_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[IDX_W-1:0];
                end else if (!cmp_vld_reg) begin
                    state_next = S_DONE;
                end
            end
            S_ADJ_RD: begin
                rd_addr    = idx_addr;
                state_next = S_ADJ;
            end
            S_ADJ: begin
                hit_rec_next = rd_entry;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (mode_reg == MODE_LOOKUP) begin
                    if (hit_found_reg) begin
                        e_out   = hit_wide[IDX_IN_W-1:0];
                        r_hit   = 1'b1;
                        wr_addr = hit_idx_reg;
                        if (hit_rec_reg.cnt == COUNT_MAX) begin
                            r_stat = ST_COUNT;
                        end else begin
                            r_fill        = !hit_rec_reg.valid;
                            wr_en         = 1'b1;
                            wr_data.cnt   = hit_rec_reg.cnt + 1'b1;
                            wr_data.stamp = now_reg;
                            wr_data.valid = 1'b1;
                        end
                    end else if (free_found_reg) begin
                        e_out         = free_wide[IDX_IN_W-1:0];
                        r_fill        = 1'b1;
                        wr_en         = 1'b1;
                        wr_addr       = free_idx_reg;
                        wr_data.dev   = dev_reg;
                        wr_data.blk   = blk_reg;
                        wr_data.valid = 1'b1;
                        wr_data.cnt   = CNT_W'(1);
                        wr_data.stamp = oldest_reg;
                    end else begin
                        e_out  = '0;
                        r_stat = ST_FULL;
                    end
                end else if (idx_ok) begin
                    wr_addr = idx_addr;
                    if (mode_reg == MODE_PIN) begin
                        if (hit_rec_reg.cnt == COUNT_MAX) begin
                            r_stat = ST_COUNT;
                        end else begin
                            wr_en       = 1'b1;
                            wr_data.cnt = hit_rec_reg.cnt + 1'b1;
                        end
                    end else if (hit_rec_reg.cnt == '0) begin
                        r_stat = ST_COUNT;
                    end else begin
                        wr_en       = 1'b1;
                        wr_data.cnt = hit_rec_reg.cnt - 1'b1;
                        if (mode_reg == MODE_RELEASE && hit_rec_reg.cnt == CNT_W'(1)) begin
                            wr_data.stamp = now_reg;
                        end
                    end
                end
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, r_stat, r_fill, r_hit, e_out};
                    state_next    = S_IDLE;
                end else begin
                    wr_en = 1'b0;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            live_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            cmp_vld_reg    <= cmp_vld_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (wr_en) begin
                live_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        dev_reg      <= dev_next;
        blk_reg      <= blk_next;
        idx_reg      <= idx_next;
        now_reg      <= now_next;
        scan_reg     <= scan_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_rec_reg  <= hit_rec_next;
        free_idx_reg <= free_idx_next;
        oldest_reg   <= oldest_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

`default_nettype wire

// File: tb/sv/block_cache_tag_table_lru_tb.sv
// Self-checking testbench for the block cache tag table with LRU replacement.
// Streams lookup, release, pin and unpin words, predicts each reply and checks it.
// Depends on bctt_pkg and block_cache_tag_table_lru.
`timescale 1ns / 1ps

module block_cache_tag_table_lru_tb;
    import bctt_pkg::*;

    localparam int NUM_ENT    = 32;
    localparam int WATCHDOG   = 5000;
    localparam int DRAIN_WAIT = 64;
    localparam int LONG_HOLD  = 300;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [4:0]  idx;
        logic [31:0] now;
    } cache_op_t;

    typedef struct packed {
        logic [4:0] entry;
        logic       hit;
        logic       fill;
        logic [1:0] status;
    } cache_reply_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser  = '0;
    logic [79:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    cache_op_t    op_q[$];
    cache_reply_t reply_q[$];
    entry_t       plan_tab[NUM_ENT];
    entry_t       shadow_tab[NUM_ENT];
    logic [31:0]  blk_pool[40];

    cache_op_t    cur_op;
    cache_reply_t got_reply;
    cache_reply_t want_reply;
    int           total_words = 0;
    int           words_in    = 0;
    int           words_out   = 0;
    int           err_cnt     = 0;
    int           quiet_cycles = 0;
    int           hold_left   = 0;
    bit           hold_done   = 1'b0;
    int           send_idle;
    int           recv_idle;

    block_cache_tag_table_lru #(
        .NUM_ENTRIES(NUM_ENT)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic cache_reply_t table_access(ref entry_t tab[NUM_ENT],
                                                  input cache_op_t op);
        cache_reply_t r;
        bit           found;
        int           pick;
        logic [31:0]  oldest;
        r      = '0;
        found  = 1'b0;
        pick   = 0;
        oldest = '0;
        r.entry = op.idx;
        if (op.mode == MODE_LOOKUP) begin
            for (int i = 0; i < NUM_ENT; i++) begin
                if (!found && tab[i].dev == op.dev && tab[i].blk == op.blk) begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            if (found) begin
                r.entry = pick[4:0];
                r.hit   = 1'b1;
                if (tab[pick].cnt == COUNT_MAX) begin
                    r.status = ST_COUNT;
                end else begin
                    tab[pick].cnt   = tab[pick].cnt + 1'b1;
                    tab[pick].stamp = op.now;
                    r.fill          = ~tab[pick].valid;
                    tab[pick].valid = 1'b1;
                    r.status        = ST_OK;
                end
            end else begin
                for (int i = 0; i < NUM_ENT; i++) begin
                    if (tab[i].cnt == '0 && (!found || tab[i].stamp < oldest)) begin
                        found  = 1'b1;
                        pick   = i;
                        oldest = tab[i].stamp;
                    end
                end
                if (!found) begin
                    r.entry  = '0;
                    r.status = ST_FULL;
                end else begin
                    tab[pick].dev   = op.dev;
                    tab[pick].blk   = op.blk;
                    tab[pick].cnt   = 8'd1;
                    tab[pick].valid = 1'b1;
                    r.entry  = pick[4:0];
                    r.fill   = 1'b1;
                    r.status = ST_OK;
                end
            end
        end else if (int'(op.idx) < NUM_ENT) begin
            if (op.mode == MODE_PIN) begin
                if (tab[op.idx].cnt == COUNT_MAX)
                    r.status = ST_COUNT;
                else
                    tab[op.idx].cnt = tab[op.idx].cnt + 1'b1;
            end else if (tab[op.idx].cnt == '0) begin
                r.status = ST_COUNT;
            end else begin
                tab[op.idx].cnt = tab[op.idx].cnt - 1'b1;
                if (op.mode == MODE_RELEASE && tab[op.idx].cnt == '0)
                    tab[op.idx].stamp = op.now;
            end
        end
        return r;
    endfunction

    function automatic cache_reply_t push_op(input logic [1:0] mode, input logic [7:0] dev,
                                             input logic [31:0] blk, input logic [4:0] idx,
                                             input logic [31:0] now);
        cache_op_t op;
        op = '{mode, dev, blk, idx, now};
        op_q.push_back(op);
        return table_access(plan_tab, op);
    endfunction

    function automatic logic [4:0] pick_held();
        int held[$];
        foreach (plan_tab[i])
            if (plan_tab[i].cnt != '0)
                held.push_back(i);
        if (held.size() == 0)
            return 5'($urandom_range(NUM_ENT - 1, 0));
        return 5'(held[$urandom_range(held.size() - 1, 0)]);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (err_cnt < MAX_PRINTS)
            $display("mismatch at result word %0d: %s got 0x%0h want 0x%0h",
                     words_out, what, got, want);
        err_cnt++;
    endtask

    // stimulus plan and end of run
    initial begin
        cache_reply_t r;
        logic [31:0]  tick;
        int           sel;
        int           e;
        int           guard;
        int           fills;
        bit           pin_done;
        tick     = 32'd100;
        fills    = 0;
        pin_done = 1'b0;
        foreach (plan_tab[i]) begin
            plan_tab[i]   = '0;
            shadow_tab[i] = '0;
        end
        foreach (blk_pool[i])
            blk_pool[i] = (i < 8) ? 32'(i) : $urandom;

        void'(push_op(MODE_LOOKUP, 8'h00, 32'h0, 5'h1F, 32'd10));
        void'(push_op(MODE_LOOKUP, 8'h00, 32'h0, 5'h00, 32'd11));
        void'(push_op(MODE_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 5'h1F, 32'hFFFF_FFFF));
        void'(push_op(MODE_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd1, 32'hFFFF_FFFF));
        void'(push_op(MODE_RELEASE, 8'h00, 32'h0, 5'd1, 32'd12));
        void'(push_op(MODE_UNPIN, 8'h00, 32'h0, 5'd31, 32'd13));
        void'(push_op(MODE_PIN, 8'hA5, 32'h5A5A_A5A5, 5'd31, 32'd14));
        void'(push_op(MODE_UNPIN, 8'h5A, 32'hA5A5_5A5A, 5'd31, 32'd15));
        void'(push_op(MODE_RELEASE, 8'h00, 32'h0, 5'd0, 32'd5));
        void'(push_op(MODE_RELEASE, 8'h00, 32'h0, 5'd0, 32'd5));
        void'(push_op(MODE_LOOKUP, 8'h01, 32'd7, 5'd0, 32'd20));
        void'(push_op(MODE_LOOKUP, 8'h00, 32'h0, 5'd0, 32'd21));
        void'(push_op(MODE_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd22));
        void'(push_op(MODE_PIN, 8'h00, 32'h0, 5'd0, 32'd0));
        void'(push_op(MODE_UNPIN, 8'h00, 32'h0, 5'd0, 32'd0));
        void'(push_op(MODE_RELEASE, 8'h00, 32'h0, 5'd0, 32'd23));
        void'(push_op(MODE_RELEASE, 8'h00, 32'h0, 5'd1, 32'd23));
        void'(push_op(MODE_RELEASE, 8'h00, 32'h0, 5'd2, 32'd23));
        void'(push_op(MODE_LOOKUP, 8'h02, 32'd9, 5'd0, 32'd24));

        while (op_q.size() < 1570) begin
            tick = tick + 32'($urandom_range(3, 0));
            sel  = $urandom_range(999, 0);
            if (sel < 15 && fills < 4) begin
                // fill every entry, overrun once, then hand them all back
                fills++;
                guard = 0;
                do begin
                    r = push_op(MODE_LOOKUP, 8'($urandom), $urandom, 5'($urandom), tick);
                    guard++;
                end while (r.status != ST_FULL && guard < 40);
                void'(push_op(MODE_LOOKUP, 8'($urandom_range(3, 0)),
                              blk_pool[$urandom_range(39, 0)], 5'($urandom), tick));
                foreach (plan_tab[i]) begin
                    while (plan_tab[i].cnt != '0) begin
                        tick = tick + 32'($urandom_range(2, 0));
                        void'(push_op(MODE_RELEASE, 8'($urandom), $urandom, 5'(i), tick));
                    end
                end
            end else if (!pin_done && op_q.size() >= 700) begin
                // drive one count to saturation and back past zero
                pin_done = 1'b1;
                e = $urandom_range(NUM_ENT - 1, 0);
                while (plan_tab[e].cnt != COUNT_MAX)
                    void'(push_op(MODE_PIN, 8'($urandom), $urandom, 5'(e), $urandom));
                void'(push_op(MODE_PIN, 8'($urandom), $urandom, 5'(e), $urandom));
                void'(push_op(MODE_LOOKUP, plan_tab[e].dev, plan_tab[e].blk,
                              5'($urandom), tick));
                while (plan_tab[e].cnt != '0)
                    void'(push_op(MODE_UNPIN, 8'($urandom), $urandom, 5'(e), $urandom));
                void'(push_op(MODE_UNPIN, 8'($urandom), $urandom, 5'(e), $urandom));
            end else if (sel < 360) begin
                void'(push_op(MODE_LOOKUP, 8'($urandom_range(3, 0)),
                              blk_pool[$urandom_range(39, 0)], 5'($urandom), tick));
            end else if (sel < 600) begin
                void'(push_op(MODE_RELEASE, 8'($urandom), $urandom, pick_held(), tick));
            end else if (sel < 680) begin
                void'(push_op(MODE_PIN, 8'($urandom), $urandom, pick_held(), tick));
            end else if (sel < 760) begin
                void'(push_op(MODE_UNPIN, 8'($urandom), $urandom, pick_held(), tick));
            end else if (sel < 850) begin
                void'(push_op(MODE_LOOKUP, 8'($urandom), $urandom, 5'($urandom), tick));
            end else begin
                void'(push_op(2'($urandom), 8'($urandom), $urandom, 5'($urandom),
                              $urandom));
            end
        end
        total_words = op_q.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (op_q.size() != 0 || s_tvalid || reply_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (reply_q.size() != 0)
            report_mismatch("results still outstanding", reply_q.size(), 0);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tuser  <= '0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                got_reply = table_access(shadow_tab, cur_op);
                reply_q.push_back(got_reply);
                words_in++;
            end
            if (words_in < total_words / 3)
                send_idle = 11;
            else if (words_in < 2 * (total_words / 3))
                send_idle = 78;
            else
                send_idle = 0;
            if (!s_tvalid || s_tready) begin
                // hold at the midpoint until every reply is back
                if (op_q.size() != 0 && $urandom_range(99, 0) >= send_idle
                    && !(words_in == total_words / 2 && reply_q.size() != 0)) begin
                    cur_op = op_q.pop_front();
                    s_tuser  <= cur_op.mode;
                    s_tdata  <= {3'b000, cur_op.now, cur_op.idx, cur_op.blk, cur_op.dev};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("word with no reply expected", m_tdata, 0);
                end else begin
                    want_reply = reply_q.pop_front();
                    if (m_tdata[4:0] != want_reply.entry)
                        report_mismatch("entry_out", m_tdata[4:0], want_reply.entry);
                    if (m_tdata[5] != want_reply.hit)
                        report_mismatch("hit", m_tdata[5], want_reply.hit);
                    if (m_tdata[6] != want_reply.fill)
                        report_mismatch("needs_fill", m_tdata[6], want_reply.fill);
                    if (m_tdata[8:7] != want_reply.status)
                        report_mismatch("status", m_tdata[8:7], want_reply.status);
                end
                words_out++;
            end
            if (words_out < total_words / 3)
                recv_idle = 78;
            else if (words_out < 2 * (total_words / 3))
                recv_idle = 11;
            else
                recv_idle = 0;
            if (!hold_done && words_out >= 2 * (total_words / 3) + 20) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= recv_idle);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

// File: block_cache_tag_table_lru.f
sv/bctt_pkg.sv
sv/block_cache_tag_table_lru.sv
tb/sv/block_cache_tag_table_lru_tb.sv
